// File: rtl/core/rdqf_pkg.sv
// Shared types, codes and constants of the read quality filter.
package rdqf_pkg;

   localparam int LENGTH_BITS = 20;
   localparam int SUM_BITS    = LENGTH_BITS + 7;
   localparam int PROD_BITS   = LENGTH_BITS + 7;
   localparam int OUT_BITS    = 20;
   localparam int MINLEN_BITS = 20;
   localparam int PCT_BITS    = 7;
   localparam int ADDR_BITS   = 4;
   localparam int DATA_BITS   = 32;

   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_U       = 8'h55;
   localparam logic [7:0] PHRED_OFFSET = 8'd33;
   localparam logic [6:0] AT_SCALE     = 7'd100;

   typedef enum logic [1:0] {
      REG_AT_MIN   = 2'd0,
      REG_AT_MAX   = 2'd1,
      REG_MIN_LEN  = 2'd2,
      REG_MIN_QUAL = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      VERDICT_KEEP     = 2'd0,
      VERDICT_SHORT    = 2'd1,
      VERDICT_AT_RANGE = 2'd2,
      VERDICT_LOW_QUAL = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [PCT_BITS-1:0]    at_min;
      logic [PCT_BITS-1:0]    at_max;
      logic [MINLEN_BITS-1:0] min_len;
      logic [PCT_BITS-1:0]    min_qual;
   } cfg_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] length;
      logic [LENGTH_BITS-1:0] at_count;
      logic [SUM_BITS-1:0]    quality_sum;
   } totals_type;

endpackage

// File: rtl/core/rdqf_csr.sv
// Configuration register file behind the APB-style port.
module rdqf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rdqf_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [rdqf_pkg::DATA_BITS-1:0]   pwdata,
   output logic [rdqf_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready,
   output rdqf_pkg::cfg_type                cfg
);

   localparam int DW = rdqf_pkg::DATA_BITS;
   localparam int PW = rdqf_pkg::PCT_BITS;
   localparam int LW = rdqf_pkg::MINLEN_BITS;

   rdqf_pkg::cfg_type     cfg_ff, cfg_in;
   rdqf_pkg::reg_index_type index;
   logic                  write_en;

   assign index    = rdqf_pkg::reg_index_type'(paddr[3:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            rdqf_pkg::REG_AT_MIN:   cfg_in.at_min   = pwdata[PW-1:0];
            rdqf_pkg::REG_AT_MAX:   cfg_in.at_max   = pwdata[PW-1:0];
            rdqf_pkg::REG_MIN_LEN:  cfg_in.min_len  = pwdata[LW-1:0];
            rdqf_pkg::REG_MIN_QUAL: cfg_in.min_qual = pwdata[PW-1:0];
            default:                cfg_in          = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         rdqf_pkg::REG_AT_MIN:   prdata = DW'(cfg_ff.at_min);
         rdqf_pkg::REG_AT_MAX:   prdata = DW'(cfg_ff.at_max);
         rdqf_pkg::REG_MIN_LEN:  prdata = DW'(cfg_ff.min_len);
         rdqf_pkg::REG_MIN_QUAL: prdata = DW'(cfg_ff.min_qual);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.at_min   <= '0;
         cfg_ff.at_max   <= PW'(101);
         cfg_ff.min_len  <= '0;
         cfg_ff.min_qual <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/rdqf_accum.sv
// Per-read counters and the snapshot register that hands finished reads on.
module rdqf_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_symbol,
   input  logic                  req_in_quality_line,
   input  logic                  req_carries_symbol,
   input  logic                  req_end_of_line,
   output logic                  snap_valid,
   input  logic                  snap_ready,
   output rdqf_pkg::totals_type  snap
);

   localparam int LB = rdqf_pkg::LENGTH_BITS;
   localparam int SB = rdqf_pkg::SUM_BITS;

   logic [LB-1:0] length_count_ff, length_count_in;
   logic [LB-1:0] at_count_ff, at_count_in;
   logic [SB-1:0] quality_sum_ff, quality_sum_in;
   logic [LB-1:0] quality_taken_ff, quality_taken_in;
   logic          snap_valid_ff, snap_valid_in;
   rdqf_pkg::totals_type snap_ff, snap_in;

   logic          accept;
   logic          is_at;
   logic          take_quality;
   logic          closes_read;
   logic [7:0]    score;
   logic [SB:0]   sum_wide;
   logic [SB-1:0] sum_next;

   assign req_ready  = !snap_valid_ff || snap_ready;
   assign accept     = req_valid && req_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      is_at = (req_symbol == rdqf_pkg::CHAR_A) || (req_symbol == rdqf_pkg::CHAR_T) ||
              (req_symbol == rdqf_pkg::CHAR_U);
      score = (req_symbol >= rdqf_pkg::PHRED_OFFSET) ?
              req_symbol - rdqf_pkg::PHRED_OFFSET : 8'd0;
      // The carry out of the sum means saturation.
      sum_wide = {1'b0, quality_sum_ff} + (SB+1)'(score);
      sum_next = sum_wide[SB] ? {SB{1'b1}} : sum_wide[SB-1:0];
      take_quality = req_carries_symbol && (quality_taken_ff < length_count_ff);
      closes_read  = accept && req_in_quality_line && req_end_of_line;

      length_count_in  = length_count_ff;
      at_count_in      = at_count_ff;
      quality_sum_in   = quality_sum_ff;
      quality_taken_in = quality_taken_ff;
      snap_in          = snap_ff;
      snap_valid_in    = snap_valid_ff && !snap_ready;

      if (accept && !req_in_quality_line && req_carries_symbol) begin
         if (length_count_ff != {LB{1'b1}}) begin
            length_count_in = length_count_ff + LB'(1);
         end
         if (is_at && (at_count_ff != {LB{1'b1}})) begin
            at_count_in = at_count_ff + LB'(1);
         end
      end

      if (accept && req_in_quality_line && take_quality) begin
         quality_sum_in   = sum_next;
         quality_taken_in = quality_taken_ff + LB'(1);
      end

      if (closes_read) begin
         snap_in.length      = length_count_ff;
         snap_in.at_count    = at_count_ff;
         snap_in.quality_sum = take_quality ? sum_next : quality_sum_ff;
         snap_valid_in       = 1'b1;
         length_count_in     = '0;
         at_count_in         = '0;
         quality_sum_in      = '0;
         quality_taken_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_count_ff  <= '0;
         at_count_ff      <= '0;
         quality_sum_ff   <= '0;
         quality_taken_ff <= '0;
         snap_valid_ff    <= 1'b0;
      end else begin
         length_count_ff  <= length_count_in;
         at_count_ff      <= at_count_in;
         quality_sum_ff   <= quality_sum_in;
         quality_taken_ff <= quality_taken_in;
         snap_valid_ff    <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

// File: rtl/core/rdqf_judge.sv
// Product stage and verdict stage with the result register.
module rdqf_judge (
   input  logic                              clock,
   input  logic                              reset,
   input  rdqf_pkg::cfg_type                 cfg,
   input  logic                              snap_valid,
   output logic                              snap_ready,
   input  rdqf_pkg::totals_type              snap,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_keep_read,
   output logic [1:0]                        rsp_verdict,
   output logic [rdqf_pkg::OUT_BITS-1:0]     rsp_read_length,
   output logic [rdqf_pkg::OUT_BITS-1:0]     rsp_at_base_count
);

   localparam int LB = rdqf_pkg::LENGTH_BITS;
   localparam int PB = rdqf_pkg::PROD_BITS;
   localparam int OW = rdqf_pkg::OUT_BITS;
   localparam int MW = rdqf_pkg::MINLEN_BITS;
   localparam int CW = (LB > MW) ? LB : MW;

   typedef struct packed {
      logic          too_short;
      logic [PB-1:0] at100;
      logic [PB-1:0] at_lo;
      logic [PB-1:0] at_hi;
      logic [PB-1:0] qual_lo;
      logic [PB-1:0] quality_sum;
      logic [LB-1:0] length;
      logic [LB-1:0] at_count;
   } prod_type;

   prod_type              prod_ff, prod_in;
   logic                  prod_valid_ff, prod_valid_in;
   logic                  out_valid_ff, out_valid_in;
   rdqf_pkg::verdict_type verdict_ff, verdict_in;
   logic [OW-1:0]         length_ff, length_in;
   logic [OW-1:0]         at_ff, at_in;
   logic                  out_ready;
   logic                  prod_ready;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign snap_ready = prod_ready;

   always_comb begin
      prod_in.too_short   = CW'(snap.length) < CW'(cfg.min_len);
      prod_in.at100       = PB'(snap.at_count) * PB'(rdqf_pkg::AT_SCALE);
      prod_in.at_lo       = PB'(cfg.at_min) * PB'(snap.length);
      prod_in.at_hi       = PB'(cfg.at_max) * PB'(snap.length);
      prod_in.qual_lo     = PB'(cfg.min_qual) * PB'(snap.length);
      prod_in.quality_sum = PB'(snap.quality_sum);
      prod_in.length      = snap.length;
      prod_in.at_count    = snap.at_count;
      prod_valid_in       = prod_ready ? snap_valid : prod_valid_ff;
   end

   always_comb begin
      // Checks in priority order: length, then AT content, then quality.
      if (prod_ff.too_short) begin
         verdict_in = rdqf_pkg::VERDICT_SHORT;
      end else if ((prod_ff.at100 < prod_ff.at_lo) || (prod_ff.at100 >= prod_ff.at_hi)) begin
         verdict_in = rdqf_pkg::VERDICT_AT_RANGE;
      end else if (prod_ff.quality_sum < prod_ff.qual_lo) begin
         verdict_in = rdqf_pkg::VERDICT_LOW_QUAL;
      end else begin
         verdict_in = rdqf_pkg::VERDICT_KEEP;
      end
      length_in    = OW'(prod_ff.length);
      at_in        = OW'(prod_ff.at_count);
      out_valid_in = out_ready ? prod_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_ff <= prod_in;
      end
      if (out_ready) begin
         verdict_ff <= verdict_in;
         length_ff  <= length_in;
         at_ff      <= at_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_keep_read     = (verdict_ff == rdqf_pkg::VERDICT_KEEP);
   assign rsp_read_length   = length_ff;
   assign rsp_at_base_count = at_ff;

endmodule

// File: rtl/core/read_at_content_quality_filter_top.sv
// Top level of the FASTQ read filter on length, AT content and mean quality.
//
//   channel  direction  transfer when          carries
//   req      in         req_valid & req_ready  one character of a sequence or quality line
//   rsp      out        rsp_valid & rsp_ready  one verdict per read with its counts
//   csr      in/out     psel & penable         register writes and reads, pready always high
//
// One character is taken every cycle while req_ready is high; counters and the
// saturating quality sum update in the cycle of the transfer. The verdict for a
// read passes the snapshot register, the product register, where the products
// are held, and the result register, where the compares land. Reset is synchronous
// and clears the counters, the stage valids and the configuration registers to their defaults.
// A stalled rsp side backs up through three stage registers; req_ready then drops
// for any character while the snapshot stage is full and cannot move on.
module read_at_content_quality_filter_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_symbol,
   input  logic                             req_in_quality_line,
   input  logic                             req_carries_symbol,
   input  logic                             req_end_of_line,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_keep_read,
   output logic [1:0]                       rsp_verdict,
   output logic [rdqf_pkg::OUT_BITS-1:0]    rsp_read_length,
   output logic [rdqf_pkg::OUT_BITS-1:0]    rsp_at_base_count,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rdqf_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [rdqf_pkg::DATA_BITS-1:0]   pwdata,
   output logic [rdqf_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready
);

   rdqf_pkg::cfg_type    cfg;
   rdqf_pkg::totals_type snap;
   logic                 snap_valid;
   logic                 snap_ready;

   rdqf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rdqf_accum u_accum (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_symbol          (req_symbol),
      .req_in_quality_line (req_in_quality_line),
      .req_carries_symbol  (req_carries_symbol),
      .req_end_of_line     (req_end_of_line),
      .snap_valid          (snap_valid),
      .snap_ready          (snap_ready),
      .snap                (snap)
   );

   rdqf_judge u_judge (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .snap_valid        (snap_valid),
      .snap_ready        (snap_ready),
      .snap              (snap),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_keep_read     (rsp_keep_read),
      .rsp_verdict       (rsp_verdict),
      .rsp_read_length   (rsp_read_length),
      .rsp_at_base_count (rsp_at_base_count)
   );

endmodule

// File: verif/read_at_content_quality_filter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the FASTQ read filter on length, AT content and mean quality.
module read_at_content_quality_filter_top_test;
   import rdqf_pkg::*;

   localparam int              ITEMS_WANTED  = 1750;
   localparam int              PHASES        = 6;
   localparam int              HOLD_CYCLES   = 400;
   localparam int              SETTLE_CYCLES = 6;
   localparam int              DRAIN_CYCLES  = 20;
   localparam int unsigned     CYCLE_LIMIT   = 100000;
   localparam longint unsigned COUNT_MAX     = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam longint unsigned SUM_MAX       = (64'd1 << SUM_BITS) - 64'd1;

   typedef struct packed {
      logic                keep;
      verdict_type         verdict;
      logic [OUT_BITS-1:0] length;
      logic [OUT_BITS-1:0] at_count;
   } verdict_rec_type;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      reg_index_type   csr_reg;
      int unsigned     csr_value;
      logic [7:0]      sym;
      bit              qline;
      bit              carries;
      bit              eol;
      bit              typed;
      verdict_rec_type want;
   } plan_row_type;

   localparam verdict_rec_type NO_WANT = '0;

   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_symbol          = 8'h00;
   logic                  req_in_quality_line = 1'b0;
   logic                  req_carries_symbol  = 1'b0;
   logic                  req_end_of_line     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic                  rsp_keep_read;
   logic [1:0]            rsp_verdict;
   logic [OUT_BITS-1:0]   rsp_read_length;
   logic [OUT_BITS-1:0]   rsp_at_base_count;
   logic                  psel                = 1'b0;
   logic                  penable             = 1'b0;
   logic                  pwrite              = 1'b0;
   logic [ADDR_BITS-1:0]  paddr               = '0;
   logic [DATA_BITS-1:0]  pwdata              = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   // Shadow registers and per-read counters of the filter.
   cfg_type           filter_cfg    = '{at_min: 7'd0, at_max: 7'd101, min_len: '0, min_qual: '0};
   longint unsigned   seen_bases    = 0;
   longint unsigned   seen_at       = 0;
   longint unsigned   quality_total = 0;
   longint unsigned   quality_used  = 0;
   verdict_rec_type   pending_verdicts[$];
   int                error_count   = 0;
   int                items_sent    = 0;
   bit                calm          = 1'b0;
   bit                hold_start    = 1'b0;
   int unsigned       cycle_count   = 0;

   localparam int PLAN_ROWS = 29;
   plan_row_type plan [PLAN_ROWS] = '{
      // kind   register      value  symbol qline  carry  eol    typed  expected verdict
      '{ROW_ITEM, REG_AT_MIN,   0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "A",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "~",   1'b1, 1'b1, 1'b1, 1'b1,
        '{1'b1, VERDICT_KEEP, 20'd1, 20'd1}},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "T",   1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "U",   1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "a",   1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "G",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      // Quality line shorter than the read, with scores below and far above the offset.
      '{ROW_ITEM, REG_AT_MIN,   0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'd32, 1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_CSR,  REG_MIN_LEN,  2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "T",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "#",   1'b1, 1'b1, 1'b1, 1'b1,
        '{1'b0, VERDICT_SHORT, 20'd1, 20'd1}},
      '{ROW_CSR,  REG_MIN_LEN,  0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR,  REG_AT_MAX,   0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "C",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "I",   1'b1, 1'b1, 1'b1, 1'b1,
        '{1'b0, VERDICT_AT_RANGE, 20'd1, 20'd0}},
      '{ROW_CSR,  REG_AT_MAX, 101, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR,  REG_MIN_QUAL, 93, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      // A base arrives after the first quality character, and an extra one trails.
      '{ROW_ITEM, REG_AT_MIN,   0, "A",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "!",   1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "T",   1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "~",   1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, "~",   1'b1, 1'b1, 1'b1, 1'b0, NO_WANT},
      '{ROW_CSR,  REG_AT_MIN, 101, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
      '{ROW_ITEM, REG_AT_MIN,   0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_WANT}
   };

   read_at_content_quality_filter_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_symbol          (req_symbol),
      .req_in_quality_line (req_in_quality_line),
      .req_carries_symbol  (req_carries_symbol),
      .req_end_of_line     (req_end_of_line),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_keep_read       (rsp_keep_read),
      .rsp_verdict         (rsp_verdict),
      .rsp_read_length     (rsp_read_length),
      .rsp_at_base_count   (rsp_at_base_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL read_at_content_quality_filter_top");
         $finish;
      end
   end

   function automatic void report_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Updates the read counters for one transfer and judges the read at the end
   // of its quality line.
   task automatic absorb_symbol(input logic [7:0] sym, input bit qline, input bit carries,
                                input bit eol, output bit produced,
                                output verdict_rec_type rec);
      longint unsigned at100;
      verdict_type     v;
      produced = 1'b0;
      rec      = '0;
      if (!qline) begin
         if (carries) begin
            if (seen_bases < COUNT_MAX) seen_bases++;
            if ((sym == CHAR_A || sym == CHAR_T || sym == CHAR_U) && seen_at < COUNT_MAX)
               seen_at++;
         end
      end else begin
         if (carries && quality_used < seen_bases) begin
            if (sym >= PHRED_OFFSET) quality_total += longint'(sym - PHRED_OFFSET);
            if (quality_total > SUM_MAX) quality_total = SUM_MAX;
            quality_used++;
         end
         if (eol) begin
            at100 = seen_at * 100;
            if (seen_bases < filter_cfg.min_len) begin
               v = VERDICT_SHORT;
            end else if (at100 < filter_cfg.at_min * seen_bases ||
                         at100 >= filter_cfg.at_max * seen_bases) begin
               v = VERDICT_AT_RANGE;
            end else if (quality_total < filter_cfg.min_qual * seen_bases) begin
               v = VERDICT_LOW_QUAL;
            end else begin
               v = VERDICT_KEEP;
            end
            rec.keep      = (v == VERDICT_KEEP);
            rec.verdict   = v;
            rec.length    = seen_bases[OUT_BITS-1:0];
            rec.at_count  = seen_at[OUT_BITS-1:0];
            produced      = 1'b1;
            seen_bases    = 0;
            seen_at       = 0;
            quality_total = 0;
            quality_used  = 0;
         end
      end
   endtask

   task automatic send_item(input logic [7:0] sym, input bit qline, input bit carries,
                            input bit eol, input bit typed, input verdict_rec_type want);
      int              gap;
      bit              produced;
      verdict_rec_type predicted;
      gap = 0;
      if (!calm) while ($urandom_range(0, 99) < 25) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_symbol          <= sym;
      req_in_quality_line <= qline;
      req_carries_symbol  <= carries;
      req_end_of_line     <= eol;
      do @(posedge clock); while (req_ready !== 1'b1);
      absorb_symbol(sym, qline, carries, eol, produced, predicted);
      if (produced) pending_verdicts.push_back(typed ? want : predicted);
      if (qline || carries) items_sent++;
   endtask

   // Lets every outstanding verdict arrive and the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input int unsigned value);
      logic [DATA_BITS-1:0] stored;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         REG_AT_MIN: begin
            filter_cfg.at_min = value[PCT_BITS-1:0];
            stored = DATA_BITS'(filter_cfg.at_min);
         end
         REG_AT_MAX: begin
            filter_cfg.at_max = value[PCT_BITS-1:0];
            stored = DATA_BITS'(filter_cfg.at_max);
         end
         REG_MIN_LEN: begin
            filter_cfg.min_len = value[MINLEN_BITS-1:0];
            stored = DATA_BITS'(filter_cfg.min_len);
         end
         default: begin
            filter_cfg.min_qual = value[PCT_BITS-1:0];
            stored = DATA_BITS'(filter_cfg.min_qual);
         end
      endcase
      // Read the register straight back; psel stays high into the read setup.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      report_field("register readback", stored, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      // Leaves the port idle before anything else is driven.
      @(posedge clock);
   endtask

   // One well-formed read with random content: mostly short, with quality lines
   // that sometimes fall short of or run past the sequence.
   task automatic send_random_read();
      int         base_count;
      int         qual_count;
      int         at_share;
      int         qual_level;
      int         pick;
      int         i;
      logic [7:0] sym;
      pick = $urandom_range(0, 99);
      if (pick < 80) base_count = $urandom_range(0, 6);
      else if (pick < 97) base_count = $urandom_range(7, 30);
      else base_count = $urandom_range(31, 150);
      at_share = $urandom_range(0, 100);
      if (base_count == 0) send_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_WANT);
      for (i = 0; i < base_count; i++) begin
         if ($urandom_range(0, 99) < 3)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0, NO_WANT);
         if ($urandom_range(0, 99) < 8) begin
            sym = 8'($urandom_range(0, 255));
         end else if ($urandom_range(0, 99) < at_share) begin
            case ($urandom_range(0, 2))
               0:       sym = CHAR_A;
               1:       sym = CHAR_T;
               default: sym = CHAR_U;
            endcase
         end else begin
            case ($urandom_range(0, 5))
               0:       sym = "C";
               1:       sym = "G";
               2:       sym = "N";
               3:       sym = "a";
               4:       sym = "t";
               default: sym = "u";
            endcase
         end
         send_item(sym, 1'b0, 1'b1, i == base_count - 1, 1'b0, NO_WANT);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) qual_count = base_count;
      else if (pick < 90) qual_count = $urandom_range(0, base_count);
      else qual_count = base_count + $urandom_range(1, 5);
      qual_level = $urandom_range(0, 60);
      if (qual_count == 0) send_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_WANT);
      for (i = 0; i < qual_count; i++) begin
         if ($urandom_range(0, 99) < 3)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, 1'b0, NO_WANT);
         if ($urandom_range(0, 99) < 8) sym = 8'($urandom_range(0, 255));
         else sym = 8'(28 + qual_level + $urandom_range(0, 10));
         send_item(sym, 1'b1, 1'b1, i == qual_count - 1, 1'b0, NO_WANT);
      end
   endtask

   // Result side: checks every verdict transfer and drives rsp_ready.
   initial begin
      int              hold_left;
      bit              hold_done;
      verdict_rec_type want;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual verdict %0d length %0d",
                        $time, rsp_verdict, rsp_read_length);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               report_field("keep_read", want.keep, rsp_keep_read);
               report_field("verdict", want.verdict, rsp_verdict);
               report_field("read_length", want.length, rsp_read_length);
               report_field("at_base_count", want.at_count, rsp_at_base_count);
            end
         end
         if (hold_start && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   initial begin
      int          row;
      int          phase;
      int          phase_end;
      int unsigned at_lo;
      int unsigned at_hi;
      int unsigned len_min;
      int unsigned qual_min;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         if (plan[row].kind == ROW_CSR) begin
            settle();
            write_register(plan[row].csr_reg, plan[row].csr_value);
         end else begin
            send_item(plan[row].sym, plan[row].qline, plan[row].carries, plan[row].eol,
                      plan[row].typed, plan[row].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         if (phase == 0) begin
            at_lo = 0; at_hi = 101; len_min = 0; qual_min = 0;
         end else if (phase == 1) begin
            at_lo = 101; at_hi = 0; len_min = 1048575; qual_min = 93;
         end else begin
            at_lo    = $urandom_range(0, 70);
            at_hi    = $urandom_range(at_lo, 101);
            len_min  = $urandom_range(0, 16);
            qual_min = $urandom_range(0, 45);
         end
         write_register(REG_AT_MIN, at_lo);
         write_register(REG_AT_MAX, at_hi);
         write_register(REG_MIN_LEN, len_min);
         write_register(REG_MIN_QUAL, qual_min);
         calm = (phase == 3);
         // The receiver stalls for a long stretch while reads keep coming.
         if (phase == 2) hold_start = 1'b1;
         phase_end = items_sent + ITEMS_WANTED / PHASES;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 8) begin
               repeat ($urandom_range(1, 4))
                  send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
            end
            send_random_read();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS read_at_content_quality_filter_top");
      end else begin
         $display("FAIL read_at_content_quality_filter_top");
      end
      $finish;
   end

endmodule
